>>> design/hant_pkg.sv
// Shared types and codes for the hashed neighbor table.
package hant_pkg;

  // Request codes carried in the action field.
  localparam logic [2:0] ACT_LOOKUP   = 3'd0;
  localparam logic [2:0] ACT_ADD_RES  = 3'd1;
  localparam logic [2:0] ACT_ADD_PEND = 3'd2;
  localparam logic [2:0] ACT_ENQUEUE  = 3'd3;
  localparam logic [2:0] ACT_STAMP    = 3'd4;

  // Result status codes.
  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_DROPPED = 2'd1;
  localparam logic [1:0] RES_NO_PEND = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [3:0] REG_HASH_MULT = 4'd0;
  localparam logic [3:0] REG_PEND_LIM  = 4'd1;

  // Widest way index for the largest supported associativity.
  localparam int WAY_IDX_W = 4;

  typedef enum logic [1:0] {
    EST_FREE = 2'd0,
    EST_PEND = 2'd1,
    EST_RES  = 2'd2
  } entry_st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_PROC,
    S_OUT
  } fsm_e;

  typedef struct packed {
    entry_st_e   st;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] res_time;
    logic [31:0] req_time;
    logic [3:0]  qcnt;
  } entry_t;

  // Outcome of comparing one set against an address.
  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 full;
    logic [WAY_IDX_W-1:0] slot;
  } match_t;

endpackage

>>> design/hant_match.sv
// Way compare, free-way search and eviction victim choice for one set.
module hant_match #(
  parameter int WAYS = 4
) (
  input  hant_pkg::entry_t [WAYS-1:0] row_i,
  input  logic [31:0]                 ip_i,
  output hant_pkg::match_t            match_o
);

  always_comb begin
    logic                           have_free;
    logic                           have_res;
    logic                           have_pend;
    logic [31:0]                    best_res;
    logic [31:0]                    best_pend;
    logic [hant_pkg::WAY_IDX_W-1:0] free_way;
    logic [hant_pkg::WAY_IDX_W-1:0] res_way;
    logic [hant_pkg::WAY_IDX_W-1:0] pend_way;
    match_o   = '0;
    have_free = 1'b0;
    have_res  = 1'b0;
    have_pend = 1'b0;
    best_res  = '0;
    best_pend = '0;
    free_way  = '0;
    res_way   = '0;
    pend_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      // First live way that holds the address.
      if (!match_o.hit && row_i[w].st != hant_pkg::EST_FREE && row_i[w].ip == ip_i) begin
        match_o.hit     = 1'b1;
        match_o.hit_way = hant_pkg::WAY_IDX_W'(w);
      end
      if (!have_free && row_i[w].st == hant_pkg::EST_FREE) begin
        have_free = 1'b1;
        free_way  = hant_pkg::WAY_IDX_W'(w);
      end
      // Oldest resolved and oldest pending, first way wins ties.
      if (row_i[w].st == hant_pkg::EST_RES && (!have_res || row_i[w].res_time < best_res)) begin
        have_res = 1'b1;
        best_res = row_i[w].res_time;
        res_way  = hant_pkg::WAY_IDX_W'(w);
      end
      if (row_i[w].st == hant_pkg::EST_PEND &&
          (!have_pend || row_i[w].req_time < best_pend)) begin
        have_pend = 1'b1;
        best_pend = row_i[w].req_time;
        pend_way  = hant_pkg::WAY_IDX_W'(w);
      end
    end
    match_o.full = !have_free;
    if (have_free) begin
      match_o.slot = free_way;
    end else if (have_res) begin
      match_o.slot = res_way;
    end else begin
      match_o.slot = pend_way;
    end
  end

endmodule

>>> design/hashed_arp_neighbor_table_unit.sv
// Top level of the hashed set-associative neighbor table.
// A request is accepted in the idle state and its result is valid after the hash multiply,
// the set read from the row memory, and compare with write back.
// One request is in flight at a time. The next request is accepted only once the result
// is taken, so an output stall also holds off the next request.
// Reset clears per-row valid flops at once, so every entry reads as free right away.
module hashed_arp_neighbor_table_unit #(
  parameter int SET_BITS  = 4,
  parameter int WAYS      = 4,
  parameter int QUEUE_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] ip_addr_i,
  input  logic [47:0] mac_addr_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [1:0]  entry_state_o,
  output logic [47:0] mac_out_o,
  output logic [1:0]  status_o,
  output logic [3:0]  set_index_o,
  output logic [1:0]  way_index_o,
  output logic [3:0]  release_count_o,
  output logic [3:0]  drop_count_o,
  output logic        evicted_o,
  output logic [31:0] evicted_ip_o
);

  localparam int NSETS = 1 << SET_BITS;
  localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [6:0] QMAX = 7'(QUEUE_MAX);

  hant_pkg::fsm_e state_q, state_d;

  logic [31:0] hash_mult_q;
  logic [3:0]  pend_lim_q;

  logic [2:0]  act_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [31:0] now_q;
  logic [SET_BITS-1:0] set_q;

  hant_pkg::entry_t [WAYS-1:0] mem [NSETS];
  hant_pkg::entry_t [WAYS-1:0] rd_q;
  logic [NSETS-1:0] row_vld_q;
  logic             rd_vld_q;

  hant_pkg::entry_t [WAYS-1:0] row;
  hant_pkg::entry_t [WAYS-1:0] new_row;
  hant_pkg::match_t            match;

  logic        found_q, evicted_q;
  logic [1:0]  estate_q, status_q, way_q;
  logic [47:0] mac_out_q;
  logic [3:0]  rel_q, drop_q;
  logic [31:0] evip_q;

  logic        found_d, evicted_d;
  logic [1:0]  estate_d, status_d, way_d;
  logic [47:0] mac_out_d;
  logic [3:0]  rel_d, drop_d;
  logic [31:0] evip_d;

  logic [31:0] product;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != hant_pkg::S_IDLE);
  assign out_valid_o = (state_q == hant_pkg::S_OUT);
  assign product     = ip_q * hash_mult_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mult_q <= 32'd1640531527;
      pend_lim_q  <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hant_pkg::REG_HASH_MULT: hash_mult_q <= cfg_data_i;
        hant_pkg::REG_PEND_LIM:  pend_lim_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hant_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hant_pkg::S_IDLE: if (in_valid_i) state_d = hant_pkg::S_HASH;
      hant_pkg::S_HASH: state_d = hant_pkg::S_READ;
      hant_pkg::S_READ: state_d = hant_pkg::S_PROC;
      hant_pkg::S_PROC: state_d = hant_pkg::S_OUT;
      hant_pkg::S_OUT:  if (!out_stall_i) state_d = hant_pkg::S_IDLE;
      default:          state_d = hant_pkg::S_IDLE;
    endcase
  end

  // Request capture and hashed set.
  always_ff @(posedge clk_i) begin
    if (state_q == hant_pkg::S_IDLE && in_valid_i) begin
      act_q <= action_i;
      ip_q  <= ip_addr_i;
      mac_q <= mac_addr_i;
      now_q <= now_i;
    end
    if (state_q == hant_pkg::S_HASH) begin
      set_q <= product[31 -: SET_BITS];
    end
  end

  // Set memory: one read, one write back per request.
  always_ff @(posedge clk_i) begin
    if (state_q == hant_pkg::S_READ) begin
      rd_q <= mem[set_q];
    end
    if (state_q == hant_pkg::S_PROC) begin
      mem[set_q] <= new_row;
    end
  end

  // Row valid flops make never-written rows read as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (state_q == hant_pkg::S_READ) rd_vld_q <= row_vld_q[set_q];
      if (state_q == hant_pkg::S_PROC) row_vld_q[set_q] <= 1'b1;
    end
  end

  assign row = rd_vld_q ? rd_q : '0;

  hant_match #(
    .WAYS(WAYS)
  ) u_match (
    .row_i  (row),
    .ip_i   (ip_q),
    .match_o(match)
  );

  // Request rules and result fields.
  always_comb begin
    logic [6:0]    limit;
    logic [WB-1:0] tw;
    logic          have_way;
    logic          is_add;
    hant_pkg::entry_st_e kind;
    hant_pkg::entry_t    cur;
    limit     = ({3'd0, pend_lim_q} < QMAX) ? {3'd0, pend_lim_q} : QMAX;
    is_add    = (act_q == hant_pkg::ACT_ADD_RES) || (act_q == hant_pkg::ACT_ADD_PEND);
    kind      = (act_q == hant_pkg::ACT_ADD_RES) ? hant_pkg::EST_RES : hant_pkg::EST_PEND;
    tw        = match.hit ? match.hit_way[WB-1:0] : match.slot[WB-1:0];
    have_way  = match.hit || is_add;
    new_row   = row;
    cur       = row[tw];
    status_d  = hant_pkg::RES_OK;
    rel_d     = '0;
    drop_d    = '0;
    evicted_d = 1'b0;
    evip_d    = '0;
    if (is_add) begin
      if (match.hit) begin
        if (cur.st == hant_pkg::EST_RES && kind == hant_pkg::EST_RES) begin
          new_row[tw].mac      = mac_q;
          new_row[tw].res_time = now_q;
        end else if (cur.st == hant_pkg::EST_RES) begin
          new_row[tw].st       = hant_pkg::EST_PEND;
          new_row[tw].mac      = '0;
          new_row[tw].res_time = '0;
          new_row[tw].req_time = '0;
          new_row[tw].qcnt     = '0;
        end else if (kind == hant_pkg::EST_RES) begin
          new_row[tw].st       = hant_pkg::EST_RES;
          new_row[tw].mac      = mac_q;
          new_row[tw].res_time = now_q;
          new_row[tw].qcnt     = '0;
          rel_d                = cur.qcnt;
        end
      end else begin
        if (match.full) begin
          evicted_d = 1'b1;
          evip_d    = cur.ip;
          drop_d    = cur.qcnt;
        end
        new_row[tw].st       = kind;
        new_row[tw].ip       = ip_q;
        new_row[tw].mac      = mac_q;
        new_row[tw].res_time = (kind == hant_pkg::EST_RES) ? now_q : '0;
        new_row[tw].req_time = '0;
        new_row[tw].qcnt     = '0;
      end
    end else if (act_q == hant_pkg::ACT_ENQUEUE || act_q == hant_pkg::ACT_STAMP) begin
      if (!match.hit || cur.st != hant_pkg::EST_PEND) begin
        status_d = hant_pkg::RES_NO_PEND;
      end else if (act_q == hant_pkg::ACT_ENQUEUE) begin
        if ({3'd0, cur.qcnt} >= limit) begin
          status_d = hant_pkg::RES_DROPPED;
        end else begin
          new_row[tw].qcnt = cur.qcnt + 4'd1;
        end
      end else begin
        new_row[tw].req_time = now_q;
      end
    end
    found_d   = match.hit;
    estate_d  = have_way ? new_row[tw].st : 2'd0;
    mac_out_d = have_way ? new_row[tw].mac : '0;
    way_d     = have_way ? tw[1:0] : 2'd0;
    if (WB < 2) way_d = have_way ? 2'(tw) : 2'd0;
  end

  // Result register, held while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (state_q == hant_pkg::S_PROC) begin
      found_q   <= found_d;
      estate_q  <= estate_d;
      mac_out_q <= mac_out_d;
      status_q  <= status_d;
      way_q     <= way_d;
      rel_q     <= rel_d;
      drop_q    <= drop_d;
      evicted_q <= evicted_d;
      evip_q    <= evip_d;
    end
  end

  assign found_o         = found_q;
  assign entry_state_o   = estate_q;
  assign mac_out_o       = mac_out_q;
  assign status_o        = status_q;
  assign set_index_o     = 4'(set_q);
  assign way_index_o     = way_q;
  assign release_count_o = rel_q;
  assign drop_count_o    = drop_q;
  assign evicted_o       = evicted_q;
  assign evicted_ip_o    = evip_q;

endmodule
